@@ sv/assert_macros.svh @@
// Assertion macros shared by the checker files of this project.
// No dependencies; every macro takes a label, a clock, an active-low reset and a message.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ECAL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ECAL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/ecal_pkg.sv @@
// Package for the epoch seconds to calendar converter: types, constants,
// the microcode table and the month length table. No dependencies.
package ecal_pkg;

    // Field and datapath widths.
    localparam int EPOCH_W = 31;
    localparam int DAYS_W  = 15;
    localparam int PC_W    = 6;

    // Divisors and calendar constants.
    localparam logic [EPOCH_W-1:0] SECS_PER_DAY  = 31'd86400;
    localparam logic [EPOCH_W-1:0] SECS_PER_HOUR = 31'd3600;
    localparam logic [EPOCH_W-1:0] SECS_PER_MIN  = 31'd60;
    localparam logic [EPOCH_W-1:0] DAYS_PER_WEEK = 31'd7;
    localparam logic [EPOCH_W-1:0] YEAR_DAYS     = 31'd365;
    localparam logic [EPOCH_W-1:0] LEAP_YEAR_DAYS = 31'd366;
    localparam logic [10:0] BASE_YEAR = 11'd1970;
    // 1970-01-01 was a Thursday.
    localparam logic [EPOCH_W-1:0] EPOCH_WEEKDAY = 31'd4;
    localparam logic [3:0] LAST_MONTH_IDX = 4'd11;

    // Program counter layout of the microcode.
    localparam logic [PC_W-1:0] PC_DAY_FIRST  = 6'd0;
    localparam logic [PC_W-1:0] PC_DAY_LAST   = 6'd14;
    localparam logic [PC_W-1:0] PC_TAKE_DAYS  = 6'd15;
    localparam logic [PC_W-1:0] PC_HOUR_FIRST = 6'd16;
    localparam logic [PC_W-1:0] PC_HOUR_LAST  = 6'd20;
    localparam logic [PC_W-1:0] PC_TAKE_HOUR  = 6'd21;
    localparam logic [PC_W-1:0] PC_MIN_FIRST  = 6'd22;
    localparam logic [PC_W-1:0] PC_MIN_LAST   = 6'd27;
    localparam logic [PC_W-1:0] PC_TAKE_MIN   = 6'd28;
    localparam logic [PC_W-1:0] PC_WEEK_FIRST = 6'd29;
    localparam logic [PC_W-1:0] PC_WEEK_LAST  = 6'd41;
    localparam logic [PC_W-1:0] PC_TAKE_WDAY  = 6'd42;
    localparam logic [PC_W-1:0] PC_YEAR       = 6'd43;
    localparam logic [PC_W-1:0] PC_MONTH      = 6'd44;
    localparam logic [PC_W-1:0] PC_DONE       = 6'd45;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_DIV,
        OP_TAKE_DAYS,
        OP_TAKE_HOUR,
        OP_TAKE_MIN,
        OP_TAKE_WDAY,
        OP_YEAR,
        OP_MONTH,
        OP_DONE
    } t_op;

    typedef enum logic {
        JMP_NEXT,
        JMP_IF_MORE
    } t_jmp;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    // One microcode control word.
    typedef struct packed {
        t_op               op;
        logic [EPOCH_W-1:0] operand;
        t_jmp              jmp;
        logic [PC_W-1:0]   target;
    } t_ctrl;

    // Sequencer to datapath controls.
    typedef struct packed {
        logic  load;
        logic  run;
        t_ctrl word;
    } t_dp_ctl;

    // Datapath to sequencer status.
    typedef struct packed {
        logic more;
    } t_dp_status;

    // Days in a month, February taking 29 in a leap year.
    function automatic logic [4:0] days_in_month(input logic [3:0] idx, input logic leap);
        logic [4:0] len;
        case (idx)
            4'd1:                len = leap ? 5'd29 : 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10: len = 5'd30;
            default:             len = 5'd31;
        endcase
        return len;
    endfunction

    // Microcode table: restoring divisions by day, hour, minute and week,
    // then the year and month walks.
    function automatic t_ctrl ucode(input logic [PC_W-1:0] pc);
        t_ctrl w;
        w.op      = OP_NOP;
        w.operand = '0;
        w.jmp     = JMP_NEXT;
        w.target  = '0;
        case (pc) inside
            [PC_DAY_FIRST:PC_DAY_LAST]: begin
                w.op      = OP_DIV;
                w.operand = SECS_PER_DAY << (PC_DAY_LAST - pc);
            end
            PC_TAKE_DAYS: w.op = OP_TAKE_DAYS;
            [PC_HOUR_FIRST:PC_HOUR_LAST]: begin
                w.op      = OP_DIV;
                w.operand = SECS_PER_HOUR << (PC_HOUR_LAST - pc);
            end
            PC_TAKE_HOUR: w.op = OP_TAKE_HOUR;
            [PC_MIN_FIRST:PC_MIN_LAST]: begin
                w.op      = OP_DIV;
                w.operand = SECS_PER_MIN << (PC_MIN_LAST - pc);
            end
            PC_TAKE_MIN: w.op = OP_TAKE_MIN;
            [PC_WEEK_FIRST:PC_WEEK_LAST]: begin
                w.op      = OP_DIV;
                w.operand = DAYS_PER_WEEK << (PC_WEEK_LAST - pc);
            end
            PC_TAKE_WDAY: w.op = OP_TAKE_WDAY;
            PC_YEAR: begin
                w.op     = OP_YEAR;
                w.jmp    = JMP_IF_MORE;
                w.target = PC_YEAR;
            end
            PC_MONTH: begin
                w.op     = OP_MONTH;
                w.jmp    = JMP_IF_MORE;
                w.target = PC_MONTH;
            end
            PC_DONE: w.op = OP_DONE;
            default: w.op = OP_DONE;
        endcase
        return w;
    endfunction

endpackage

@@ sv/epoch_seconds_to_calendar_unit.sv @@
// Converts epoch seconds to calendar fields by running a microcode program, one control word
// per cycle through the shared subtractor; the year and month words repeat while another
// whole year or month fits. Busy drops with the strobe and the next start transfer is
// taken at the edge that ends the strobe cycle.
// Reset is synchronous and active low; it idles the sequencer and clears the strobe.
module epoch_seconds_to_calendar_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [30:0] i_epoch_seconds,
    output logic        o_valid,
    output logic [5:0]  o_second,
    output logic [5:0]  o_minute,
    output logic [4:0]  o_hour,
    output logic [4:0]  o_day_of_month,
    output logic [3:0]  o_month,
    output logic [10:0] o_year,
    output logic [2:0]  o_weekday
);

    ecal_pkg::t_dp_ctl    w_ctl;
    ecal_pkg::t_dp_status w_status;

    // Program sequencer.
    ecal_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (w_status),
        .o_ctl    (w_ctl),
        .o_busy   (busy),
        .o_done   (o_valid)
    );

    // Arithmetic datapath.
    ecal_dp u_dp (
        .i_clk           (i_clk),
        .i_ctl           (w_ctl),
        .i_epoch_seconds (i_epoch_seconds),
        .o_status        (w_status),
        .o_second        (o_second),
        .o_minute        (o_minute),
        .o_hour          (o_hour),
        .o_day_of_month  (o_day_of_month),
        .o_month         (o_month),
        .o_year          (o_year),
        .o_weekday       (o_weekday)
    );

endmodule

@@ sv/ecal_seq.sv @@
// Microcode sequencer: program counter, control word fetch and conditional jumps.
// Depends on ecal_pkg for the control word, the status struct and the microcode table.
module ecal_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  ecal_pkg::t_dp_status i_status,
    output ecal_pkg::t_dp_ctl   o_ctl,
    output logic                o_busy,
    output logic                o_done
);

    ecal_pkg::t_state              r_state, n_state;
    logic [ecal_pkg::PC_W-1:0]     r_pc, n_pc;
    logic                          r_done, n_done;
    ecal_pkg::t_ctrl               w_word;

    assign w_word = ecal_pkg::ucode(r_pc);

    // State, program counter and result strobe registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ecal_pkg::ST_IDLE;
            r_pc    <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            r_done  <= n_done;
        end
    end

    // Next step: a new transfer restarts the program, a jump word loops on itself.
    always_comb begin
        n_state = r_state;
        n_pc    = r_pc;
        n_done  = 1'b0;
        o_ctl.load = 1'b0;
        o_ctl.run  = 1'b0;
        o_ctl.word = w_word;
        case (r_state)
            ecal_pkg::ST_IDLE: begin
                if (i_start) begin
                    o_ctl.load = 1'b1;
                    n_pc       = ecal_pkg::PC_DAY_FIRST;
                    n_state    = ecal_pkg::ST_RUN;
                end
            end
            ecal_pkg::ST_RUN: begin
                o_ctl.run = 1'b1;
                if (w_word.op == ecal_pkg::OP_DONE) begin
                    n_done  = 1'b1;
                    n_state = ecal_pkg::ST_IDLE;
                end else if (w_word.jmp == ecal_pkg::JMP_IF_MORE && i_status.more) begin
                    n_pc = w_word.target;
                end else begin
                    n_pc = ecal_pkg::PC_W'(r_pc + 1'b1);
                end
            end
            default: n_state = ecal_pkg::ST_IDLE;
        endcase
    end

    assign o_busy = (r_state == ecal_pkg::ST_RUN);
    assign o_done = r_done;

endmodule

@@ sv/ecal_dp.sv @@
// Datapath of the calendar converter: one subtract and compare unit, quotient
// shifter and the result registers. Depends on ecal_pkg.
module ecal_dp (
    input  logic                         i_clk,
    input  ecal_pkg::t_dp_ctl            i_ctl,
    input  logic [ecal_pkg::EPOCH_W-1:0] i_epoch_seconds,
    output ecal_pkg::t_dp_status         o_status,
    output logic [5:0]                   o_second,
    output logic [5:0]                   o_minute,
    output logic [4:0]                   o_hour,
    output logic [4:0]                   o_day_of_month,
    output logic [3:0]                   o_month,
    output logic [10:0]                  o_year,
    output logic [2:0]                   o_weekday
);

    logic [ecal_pkg::EPOCH_W-1:0] r_acc, n_acc;
    logic [ecal_pkg::DAYS_W-1:0]  r_q, n_q;
    logic [ecal_pkg::DAYS_W-1:0]  r_days, n_days;
    logic [5:0]                   r_sec, n_sec;
    logic [5:0]                   r_min, n_min;
    logic [4:0]                   r_hour, n_hour;
    logic [2:0]                   r_wday, n_wday;
    logic [10:0]                  r_year, n_year;
    logic [3:0]                   r_mon, n_mon;

    logic [ecal_pkg::EPOCH_W:0]   w_diff;
    logic                         w_fit;
    logic                         w_leap;
    logic [ecal_pkg::EPOCH_W-1:0] w_len;
    logic                         w_more;

    // Leap years are those divisible by four over the supported range.
    assign w_leap = (r_year[1:0] == 2'b00);

    // Length of the current year or month, depending on the walk in progress.
    always_comb begin
        if (i_ctl.word.op == ecal_pkg::OP_MONTH) begin
            w_len = {{(ecal_pkg::EPOCH_W-5){1'b0}}, ecal_pkg::days_in_month(r_mon, w_leap)};
        end else if (i_ctl.word.op == ecal_pkg::OP_YEAR) begin
            w_len = w_leap ? ecal_pkg::LEAP_YEAR_DAYS : ecal_pkg::YEAR_DAYS;
        end else begin
            w_len = i_ctl.word.operand;
        end
    end

    // Shared trial subtraction; a clear top bit means the subtrahend fits.
    assign w_diff = {1'b0, r_acc} - {1'b0, w_len};
    assign w_fit  = !w_diff[ecal_pkg::EPOCH_W];

    always_comb begin
        case (i_ctl.word.op)
            ecal_pkg::OP_YEAR:  w_more = w_fit;
            ecal_pkg::OP_MONTH: w_more = w_fit && (r_mon != ecal_pkg::LAST_MONTH_IDX);
            default:            w_more = 1'b0;
        endcase
    end
    assign o_status.more = w_more;

    // Execute one control word per cycle.
    always_comb begin
        n_acc  = r_acc;
        n_q    = r_q;
        n_days = r_days;
        n_sec  = r_sec;
        n_min  = r_min;
        n_hour = r_hour;
        n_wday = r_wday;
        n_year = r_year;
        n_mon  = r_mon;
        if (i_ctl.load) begin
            n_acc = i_epoch_seconds;
        end else if (i_ctl.run) begin
            case (i_ctl.word.op)
                ecal_pkg::OP_DIV: begin
                    if (w_fit) begin
                        n_acc = w_diff[ecal_pkg::EPOCH_W-1:0];
                    end
                    n_q = {r_q[ecal_pkg::DAYS_W-2:0], w_fit};
                end
                ecal_pkg::OP_TAKE_DAYS: n_days = r_q;
                ecal_pkg::OP_TAKE_HOUR: n_hour = r_q[4:0];
                ecal_pkg::OP_TAKE_MIN: begin
                    n_min = r_q[5:0];
                    n_sec = r_acc[5:0];
                    // The weekday is the day count offset to the epoch weekday, mod 7.
                    n_acc = ecal_pkg::EPOCH_W'({{(ecal_pkg::EPOCH_W-ecal_pkg::DAYS_W){1'b0}},
                                               r_days} + ecal_pkg::EPOCH_WEEKDAY);
                end
                ecal_pkg::OP_TAKE_WDAY: begin
                    n_wday = r_acc[2:0];
                    n_acc  = {{(ecal_pkg::EPOCH_W-ecal_pkg::DAYS_W){1'b0}}, r_days};
                    n_year = ecal_pkg::BASE_YEAR;
                    n_mon  = '0;
                end
                ecal_pkg::OP_YEAR: begin
                    if (w_more) begin
                        n_acc  = w_diff[ecal_pkg::EPOCH_W-1:0];
                        n_year = 11'(r_year + 1'b1);
                    end
                end
                ecal_pkg::OP_MONTH: begin
                    if (w_more) begin
                        n_acc = w_diff[ecal_pkg::EPOCH_W-1:0];
                        n_mon = 4'(r_mon + 1'b1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        r_acc  <= n_acc;
        r_q    <= n_q;
        r_days <= n_days;
        r_sec  <= n_sec;
        r_min  <= n_min;
        r_hour <= n_hour;
        r_wday <= n_wday;
        r_year <= n_year;
        r_mon  <= n_mon;
    end

    assign o_second       = r_sec;
    assign o_minute       = r_min;
    assign o_hour         = r_hour;
    assign o_day_of_month = 5'(r_acc[4:0] + 1'b1);
    assign o_month        = 4'(r_mon + 1'b1);
    assign o_year         = r_year;
    assign o_weekday      = r_wday;

endmodule

@@ sv/ecal_checker.sv @@
// Port-level checker for the calendar converter and its bind to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module ecal_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_valid,
    input logic [5:0]  o_second,
    input logic [5:0]  o_minute,
    input logic [4:0]  o_hour,
    input logic [4:0]  o_day_of_month,
    input logic [3:0]  o_month,
    input logic [10:0] o_year,
    input logic [2:0]  o_weekday
);

    // A start transfer makes the unit busy in the next cycle.
    `ECAL_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, start && !busy, busy, "start not taken")

    // A result is shown only once the unit has gone idle.
    `ECAL_ASSERT_NOW(a_valid_idle, i_clk, i_rst_n, o_valid, !busy, "result while busy")

    // The strobe lasts exactly one cycle.
    `ECAL_ASSERT_NEXT(a_valid_pulse, i_clk, i_rst_n, o_valid, !o_valid, "strobe too long")

    // Every transfer of a result carries a legal time of day and date.
    `ECAL_ASSERT_NOW(a_ranges, i_clk, i_rst_n, o_valid,
        o_second < 6'd60 && o_minute < 6'd60 && o_hour < 5'd24 && o_day_of_month != 5'd0
        && o_month != 4'd0 && o_month < 4'd13 && o_year > 11'd1969 && o_year < 11'd2039
        && o_weekday < 3'd7, "field out of range")

endmodule

bind epoch_seconds_to_calendar_unit ecal_checker u_ecal_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_valid        (o_valid),
    .o_second       (o_second),
    .o_minute       (o_minute),
    .o_hour         (o_hour),
    .o_day_of_month (o_day_of_month),
    .o_month        (o_month),
    .o_year         (o_year),
    .o_weekday      (o_weekday)
);
